// ===== hdl/tsm_pkg.sv =====
// Shared types and constants for the touch raw-to-screen mapper.
package tsm_pkg;

  localparam int unsigned RAW_BITS       = 12;
  localparam int unsigned SCREEN_BITS    = 10;
  localparam int unsigned DIM_BITS       = SCREEN_BITS + 1;
  localparam int unsigned MAG_BITS       = RAW_BITS + DIM_BITS;
  localparam int unsigned DIV_STEPS      = (MAG_BITS + 1) / 2;
  localparam int unsigned QUO_BITS       = 2 * DIV_STEPS;
  localparam int unsigned CFG_INDEX_BITS = 3;
  localparam int unsigned CFG_DATA_BITS  = RAW_BITS;
  localparam int unsigned FLAG_BITS      = 3;
  localparam int unsigned NUM_AXES       = 2;

  localparam int unsigned AXIS_X = 0;
  localparam int unsigned AXIS_Y = 1;

  localparam logic [FLAG_BITS-1:0] FLAG_SWAP = 3'h1;
  localparam logic [FLAG_BITS-1:0] FLAG_INVX = 3'h2;
  localparam logic [FLAG_BITS-1:0] FLAG_INVY = 3'h4;

  localparam logic [RAW_BITS-1:0] CAL_RESET     = RAW_BITS'(1);
  localparam logic [DIM_BITS-1:0] WIDTH_RESET   = DIM_BITS'(320);
  localparam logic [DIM_BITS-1:0] HEIGHT_RESET  = DIM_BITS'(240);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_X_OFFSET      = 3'd0,
    REG_X_SPAN        = 3'd1,
    REG_Y_OFFSET      = 3'd2,
    REG_Y_SPAN        = 3'd3,
    REG_ORIENT_FLAGS  = 3'd4,
    REG_SCREEN_WIDTH  = 3'd5,
    REG_SCREEN_HEIGHT = 3'd6
  } tsm_reg_e;

  typedef struct packed {
    logic [RAW_BITS-1:0] raw_x;
    logic [RAW_BITS-1:0] raw_y;
    logic [RAW_BITS-1:0] raw_pressure;
  } tsm_raw_t;

  typedef struct packed {
    logic [SCREEN_BITS-1:0] screen_x;
    logic [SCREEN_BITS-1:0] screen_y;
    logic [RAW_BITS-1:0]    pressure;
  } tsm_screen_t;

  typedef struct packed {
    logic [RAW_BITS-1:0]  x_offset;
    logic [RAW_BITS-1:0]  x_span;
    logic [RAW_BITS-1:0]  y_offset;
    logic [RAW_BITS-1:0]  y_span;
    logic [FLAG_BITS-1:0] orient_flags;
    logic [DIM_BITS-1:0]  screen_width;
    logic [DIM_BITS-1:0]  screen_height;
  } tsm_cfg_t;

  typedef struct packed {
    logic [NUM_AXES-1:0]               neg;
    logic [NUM_AXES-1:0][MAG_BITS-1:0] mag;
    logic [RAW_BITS-1:0]               pressure;
  } tsm_work_t;

endpackage

// ===== hdl/touch_raw_to_screen_mapper.sv =====
// Top level of the touch raw-to-screen mapper.
//
//   channel | handshake          | payload
//   --------+--------------------+---------------------------------------
//   samples | push / full        | in_i  : raw_x, raw_y, raw_pressure
//   results | empty / pop        | out_o : screen_x, screen_y, pressure
//   config  | cfg_valid/cfg_ready| cfg_index_i, cfg_data_i
//
// The back part's divider retires two quotient bits per cycle per axis, and
// the back part takes a new sample only when idle or as it pushes its result.
// Reset clears the queues and loads the default calibration; no clearing pass.
// A stalled result queue holds the back part, and samples keep entering the
// middle queue until it fills.
module touch_raw_to_screen_mapper #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push,
  output logic                               full,
  input  tsm_pkg::tsm_raw_t                  in_i,
  output logic                               empty,
  input  logic                               pop,
  output tsm_pkg::tsm_screen_t               out_o,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tsm_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [tsm_pkg::CFG_DATA_BITS-1:0]  cfg_data_i
);
  import tsm_pkg::*;

  tsm_cfg_t    cfg;
  tsm_work_t   work_in, work_out;
  tsm_screen_t res_in, res_out;
  logic        work_push, work_full, work_empty, work_pop;
  logic        res_push, res_full;

  tsm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  tsm_front u_front (
    .cfg_i       (cfg),
    .push_i      (push),
    .full_o      (full),
    .in_i        (in_i),
    .work_push_o (work_push),
    .work_full_i (work_full),
    .work_o      (work_in)
  );

  tsm_fifo #(
    .WIDTH ($bits(tsm_work_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_work_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (work_push),
    .data_i  (work_in),
    .full_o  (work_full),
    .pop_i   (work_pop),
    .data_o  (work_out),
    .empty_o (work_empty)
  );

  tsm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .work_valid_i (!work_empty),
    .work_i       (work_out),
    .work_pop_o   (work_pop),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (res_in)
  );

  tsm_fifo #(
    .WIDTH ($bits(tsm_screen_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign out_o = res_out;

endmodule

// ===== hdl/tsm_cfg.sv =====
// Calibration and orientation register file.
module tsm_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [tsm_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [tsm_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  output tsm_pkg::tsm_cfg_t                  cfg_o
);
  import tsm_pkg::*;

  tsm_cfg_t            cfg_q, cfg_d;
  logic [RAW_BITS-1:0] cal_val;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // zero calibration value becomes one
  assign cal_val = (cfg_data_i[RAW_BITS-1:0] == '0) ? CAL_RESET : cfg_data_i[RAW_BITS-1:0];

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_X_OFFSET:      cfg_d.x_offset      = cal_val;
        REG_X_SPAN:        cfg_d.x_span        = cal_val;
        REG_Y_OFFSET:      cfg_d.y_offset      = cal_val;
        REG_Y_SPAN:        cfg_d.y_span        = cal_val;
        REG_ORIENT_FLAGS:  cfg_d.orient_flags  = cfg_data_i[FLAG_BITS-1:0];
        REG_SCREEN_WIDTH:  cfg_d.screen_width  = cfg_data_i[DIM_BITS-1:0];
        REG_SCREEN_HEIGHT: cfg_d.screen_height = cfg_data_i[DIM_BITS-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_offset      <= CAL_RESET;
      cfg_q.x_span        <= CAL_RESET;
      cfg_q.y_offset      <= CAL_RESET;
      cfg_q.y_span        <= CAL_RESET;
      cfg_q.orient_flags  <= '0;
      cfg_q.screen_width  <= WIDTH_RESET;
      cfg_q.screen_height <= HEIGHT_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== hdl/tsm_fifo.sv =====
// Small first-in first-out queue used between and after the mapper stages.
module tsm_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== hdl/tsm_front.sv =====
// Front part: sample intake, axis swap, offset removal and scaling by screen size.
module tsm_front (
  input  tsm_pkg::tsm_cfg_t  cfg_i,
  input  logic               push_i,
  output logic               full_o,
  input  tsm_pkg::tsm_raw_t  in_i,
  output logic               work_push_o,
  input  logic               work_full_i,
  output tsm_pkg::tsm_work_t work_o
);
  import tsm_pkg::*;

  logic [NUM_AXES-1:0][RAW_BITS-1:0] raw;
  logic [NUM_AXES-1:0][RAW_BITS-1:0] off;
  logic [NUM_AXES-1:0][DIM_BITS-1:0] dim;
  logic [NUM_AXES-1:0][RAW_BITS:0]   diff;
  logic [NUM_AXES-1:0][RAW_BITS:0]   diff_abs;

  assign full_o      = work_full_i;
  assign work_push_o = push_i && !work_full_i;

  always_comb begin
    if ((cfg_i.orient_flags & FLAG_SWAP) != '0) begin
      raw[AXIS_X] = in_i.raw_y;
      raw[AXIS_Y] = in_i.raw_x;
    end else begin
      raw[AXIS_X] = in_i.raw_x;
      raw[AXIS_Y] = in_i.raw_y;
    end
    off[AXIS_X] = cfg_i.x_offset;
    off[AXIS_Y] = cfg_i.y_offset;
    dim[AXIS_X] = cfg_i.screen_width;
    dim[AXIS_Y] = cfg_i.screen_height;
    work_o.pressure = in_i.raw_pressure;
    for (int a = 0; a < NUM_AXES; a++) begin
      diff[a]        = {1'b0, raw[a]} - {1'b0, off[a]};
      diff_abs[a]    = diff[a][RAW_BITS] ? (~diff[a] + (RAW_BITS+1)'(1)) : diff[a];
      work_o.neg[a]  = diff[a][RAW_BITS];
      work_o.mag[a]  = MAG_BITS'(diff_abs[a][RAW_BITS-1:0]) * MAG_BITS'(dim[a]);
    end
  end

endmodule

// ===== hdl/tsm_back.sv =====
// Back part: signed division by span, invert and clamp for both axes.
module tsm_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tsm_pkg::tsm_cfg_t    cfg_i,
  input  logic                 work_valid_i,
  input  tsm_pkg::tsm_work_t   work_i,
  output logic                 work_pop_o,
  input  logic                 res_full_i,
  output logic                 res_push_o,
  output tsm_pkg::tsm_screen_t res_o
);
  import tsm_pkg::*;

  localparam int unsigned SW = $clog2(DIV_STEPS);
  localparam int unsigned VW = QUO_BITS + 2;
  localparam logic [VW-1:0] SCR_MAX = VW'((1 << SCREEN_BITS) - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_PUT
  } state_e;

  state_e        state_q, state_d;
  logic [SW-1:0] step_q, step_d;

  logic [NUM_AXES-1:0][QUO_BITS-1:0] quo_q, quo_d;
  logic [NUM_AXES-1:0][RAW_BITS-1:0] rem_q, rem_d;
  logic [NUM_AXES-1:0]               neg_q, neg_d;
  logic [RAW_BITS-1:0]               pres_q, pres_d;

  logic [NUM_AXES-1:0][RAW_BITS-1:0]    span;
  logic [NUM_AXES-1:0][DIM_BITS-1:0]    dim;
  logic [NUM_AXES-1:0]                  inv;
  logic [NUM_AXES-1:0][SCREEN_BITS-1:0] coord;
  logic                                 load;

  assign span[AXIS_X] = cfg_i.x_span;
  assign span[AXIS_Y] = cfg_i.y_span;
  assign dim[AXIS_X]  = cfg_i.screen_width;
  assign dim[AXIS_Y]  = cfg_i.screen_height;
  assign inv[AXIS_X]  = (cfg_i.orient_flags & FLAG_INVX) != '0;
  assign inv[AXIS_Y]  = (cfg_i.orient_flags & FLAG_INVY) != '0;

  assign res_push_o = (state_q == ST_PUT) && !res_full_i;
  assign load       = work_valid_i && ((state_q == ST_IDLE) || res_push_o);
  assign work_pop_o = load;

  // two restoring quotient bits per cycle
  always_comb begin
    logic [RAW_BITS:0]     trial;
    logic [QUO_BITS-1:0]   quo;
    logic [RAW_BITS-1:0]   rem;
    quo_d  = quo_q;
    rem_d  = rem_q;
    neg_d  = neg_q;
    pres_d = pres_q;
    trial  = '0;
    quo    = '0;
    rem    = '0;
    if (load) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        quo_d[a] = QUO_BITS'(work_i.mag[a]);
        rem_d[a] = '0;
      end
      neg_d  = work_i.neg;
      pres_d = work_i.pressure;
    end else if (state_q == ST_DIV) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        quo = quo_q[a];
        rem = rem_q[a];
        for (int b = 0; b < 2; b++) begin
          trial = {rem, quo[QUO_BITS-1]};
          quo   = {quo[QUO_BITS-2:0], 1'b0};
          if (trial >= {1'b0, span[a]}) begin
            trial  = trial - {1'b0, span[a]};
            quo[0] = 1'b1;
          end
          rem = trial[RAW_BITS-1:0];
        end
        quo_d[a] = quo;
        rem_d[a] = rem;
      end
    end
  end

  always_comb begin
    logic signed [VW-1:0] qs;
    logic signed [VW-1:0] ds;
    logic signed [VW-1:0] v;
    logic signed [VW-1:0] top;
    logic        [VW-1:0] c;
    qs = '0;
    ds = '0;
    v  = '0;
    top = '0;
    c  = '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      qs  = signed'({2'b00, quo_q[a]});
      ds  = signed'({{(VW - DIM_BITS){1'b0}}, dim[a]});
      v   = neg_q[a] ? -qs : qs;
      if (inv[a]) begin
        v = ds - v;
      end
      top = ds - VW'(1);
      if (dim[a] == '0) begin
        c = '0;
      end else if (v < 0) begin
        c = '0;
      end else if (v > top) begin
        c = top;
      end else begin
        c = v;
      end
      if (c > SCR_MAX) begin
        c = SCR_MAX;
      end
      coord[a] = c[SCREEN_BITS-1:0];
    end
  end

  assign res_o.screen_x = coord[AXIS_X];
  assign res_o.screen_y = coord[AXIS_Y];
  assign res_o.pressure = pres_q;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        if (load) begin
          state_d = ST_DIV;
          step_d  = '0;
        end
      end
      ST_DIV: begin
        step_d = step_q + SW'(1);
        if (step_q == SW'(DIV_STEPS - 1)) begin
          state_d = ST_PUT;
        end
      end
      ST_PUT: begin
        if (load) begin
          state_d = ST_DIV;
          step_d  = '0;
        end else if (res_push_o) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    neg_q  <= neg_d;
    pres_q <= pres_d;
  end

endmodule

// ===== hdl/tsm_checker.sv =====
// Port-level checks for the touch raw-to-screen mapper and their binding.
module tsm_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 push,
  input logic                 full,
  input logic                 empty,
  input logic                 pop,
  input tsm_pkg::tsm_screen_t out_o
);
  import tsm_pkg::*;

  logic [15:0] pending_q, pending_d;
  logic        in_xfer, out_xfer;

  assign in_xfer  = push && !full;
  assign out_xfer = pop && !empty;

  always_comb begin
    pending_d = pending_q;
    if (in_xfer && !out_xfer) begin
      pending_d = pending_q + 16'd1;
    end else if (out_xfer && !in_xfer) begin
      pending_d = pending_q - 16'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_o)))
    else $error("waiting result changed or vanished");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (pending_q != 16'd0))
    else $error("result shown with no sample outstanding");

  a_not_immediate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && pending_q == 16'd0) |=> empty)
    else $error("result appeared one cycle after sample transfer");

  a_full_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pending_q == 16'd0) |-> !full)
    else $error("full while no sample outstanding");

endmodule

bind touch_raw_to_screen_mapper tsm_checker u_checker (.*);
